FILE: rtl/core/rgb2g_pkg.sv
// Shared types and constants for the RGB-to-gray converter.
// Holds the method codes, config register indexes, weights and posterize tables.
// No dependencies.
package rgb2g_pkg;

    typedef enum logic [3:0] {
        M_MEAN      = 4'd0,
        M_W601      = 4'd1,
        M_REC709    = 4'd2,
        M_LIGHTNESS = 4'd3,
        M_MAX       = 4'd4,
        M_MIN       = 4'd5,
        M_BLUE      = 4'd6,
        M_GREEN     = 4'd7,
        M_RED       = 4'd8,
        M_POSTERIZE = 4'd9
    } t_gray_method;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W     = 4;
    localparam int unsigned CFG_DATA_W      = 9;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRAY_METHOD = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHADE_COUNT = 4'd1;

    localparam t_gray_method    METHOD_RESET = M_MEAN;
    localparam logic [8:0]      SHADE_RESET  = 9'd40;

    // 16-bit fractions, each set sums to 65536
    localparam logic [15:0] W601_B = 16'd7209;
    localparam logic [15:0] W601_G = 16'd38666;
    localparam logic [15:0] W601_R = 16'd19661;
    localparam logic [15:0] W709_B = 16'd4732;
    localparam logic [15:0] W709_G = 16'd46871;
    localparam logic [15:0] W709_R = 16'd13933;

    // x/3 == (x*683) >> 11 for x <= 765
    localparam logic [9:0] MEAN_RECIP = 10'd683;

    // posterize step f and ceil(65536/f); (m*recip)>>16 == m/f for m,f <= 255
    typedef struct packed {
        logic [7:0]  factor;
        logic [16:0] recip;
    } t_post;

    // d = clamped shade count minus one (1..255); f = 255/d
    function automatic t_post post_lookup(input logic [7:0] d);
        t_post res;
        case (d) inside
            [8'd128:8'd255]: res = '{8'd1,   17'((65536 + 0) / 1)};
            [8'd86:8'd127]:  res = '{8'd2,   17'((65536 + 1) / 2)};
            [8'd64:8'd85]:   res = '{8'd3,   17'((65536 + 2) / 3)};
            [8'd52:8'd63]:   res = '{8'd4,   17'((65536 + 3) / 4)};
            [8'd43:8'd51]:   res = '{8'd5,   17'((65536 + 4) / 5)};
            [8'd37:8'd42]:   res = '{8'd6,   17'((65536 + 5) / 6)};
            [8'd32:8'd36]:   res = '{8'd7,   17'((65536 + 6) / 7)};
            [8'd29:8'd31]:   res = '{8'd8,   17'((65536 + 7) / 8)};
            [8'd26:8'd28]:   res = '{8'd9,   17'((65536 + 8) / 9)};
            [8'd24:8'd25]:   res = '{8'd10,  17'((65536 + 9) / 10)};
            [8'd22:8'd23]:   res = '{8'd11,  17'((65536 + 10) / 11)};
            [8'd20:8'd21]:   res = '{8'd12,  17'((65536 + 11) / 12)};
            8'd19:           res = '{8'd13,  17'((65536 + 12) / 13)};
            8'd18:           res = '{8'd14,  17'((65536 + 13) / 14)};
            [8'd16:8'd17]:   res = '{8'd15,  17'((65536 + 14) / 15)};
            8'd15:           res = '{8'd17,  17'((65536 + 16) / 17)};
            8'd14:           res = '{8'd18,  17'((65536 + 17) / 18)};
            8'd13:           res = '{8'd19,  17'((65536 + 18) / 19)};
            8'd12:           res = '{8'd21,  17'((65536 + 20) / 21)};
            8'd11:           res = '{8'd23,  17'((65536 + 22) / 23)};
            8'd10:           res = '{8'd25,  17'((65536 + 24) / 25)};
            8'd9:            res = '{8'd28,  17'((65536 + 27) / 28)};
            8'd8:            res = '{8'd31,  17'((65536 + 30) / 31)};
            8'd7:            res = '{8'd36,  17'((65536 + 35) / 36)};
            8'd6:            res = '{8'd42,  17'((65536 + 41) / 42)};
            8'd5:            res = '{8'd51,  17'((65536 + 50) / 51)};
            8'd4:            res = '{8'd63,  17'((65536 + 62) / 63)};
            8'd3:            res = '{8'd85,  17'((65536 + 84) / 85)};
            8'd2:            res = '{8'd127, 17'((65536 + 126) / 127)};
            default:         res = '{8'd255, 17'((65536 + 254) / 255)};
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/core/rgb_to_gray_multi_method.sv
// RGB-to-gray converter top level: six-stage pipeline with a plain config port.
// Depends on rgb2g_pkg for method codes, weights and the posterize table.
//
// Takes one blue/green/red pixel per transaction and returns one 8-bit gray
// value per transaction, in order. gray_method picks the conversion: truncated
// mean, 0.11/0.59/0.3 weighting, Rec.709 weighting, lightness (max+min)/2,
// max, min, blue, green, red, or posterization of the mean (codes 10..15 give
// 0). shade_count sets the posterize levels (below 2 acts as 2, above 256 as
// 256). Throughput is one pixel per clock while the output is not stalled by
// i_ready. Each pixel passes through the six register stages (sum, max/min
// and posterize table lookup; weight and mean reciprocal multiplies; weight
// sum; posterize quotient multiply; quotient-times-step multiply; output
// select). o_ready follows i_ready combinationally through the stage-occupancy
// chain, so any empty stage absorbs a new pixel while the output waits. Config
// writes take effect for pixels accepted after the write and must only happen
// while the pipe is empty.
module rgb_to_gray_multi_method (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config port
    input  logic                                i_cfg_wr_en,
    input  logic [rgb2g_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [rgb2g_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // pixel input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_blue,
    input  logic [7:0]                          i_green,
    input  logic [7:0]                          i_red,
    // gray output
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [7:0]                          o_gray
);

    // ---------------- configuration registers ----------------
    rgb2g_pkg::t_gray_method r_method;
    logic [8:0]              r_shade;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= rgb2g_pkg::METHOD_RESET;
            r_shade  <= rgb2g_pkg::SHADE_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == rgb2g_pkg::CFG_GRAY_METHOD) begin
                r_method <= rgb2g_pkg::t_gray_method'(i_cfg_data[3:0]);
            end else if (i_cfg_index == rgb2g_pkg::CFG_SHADE_COUNT) begin
                r_shade <= i_cfg_data;
            end
        end
    end

    // ---------------- stage enables ----------------
    // A stage loads when it is empty or its content moves on.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en6;

    assign w_en6   = !r_v6 || i_ready;
    assign w_en5   = !r_v5 || w_en6;
    assign w_en4   = !r_v4 || w_en5;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
            if (w_en6) r_v6 <= r_v5;
        end
    end

    // ---------------- stage 1: sum, max, min, posterize table ----------------
    logic [7:0]  w_max, w_min, w_d;
    rgb2g_pkg::t_post w_post;

    always_comb begin
        w_max = i_blue;
        if (i_green > w_max) w_max = i_green;
        if (i_red   > w_max) w_max = i_red;
        w_min = i_blue;
        if (i_green < w_min) w_min = i_green;
        if (i_red   < w_min) w_min = i_red;
        // shade count clamped to 2..256, minus one
        if (r_shade < 9'd2) begin
            w_d = 8'd1;
        end else if (r_shade > 9'd256) begin
            w_d = 8'd255;
        end else begin
            w_d = 8'(r_shade - 9'd1);
        end
        w_post = rgb2g_pkg::post_lookup(w_d);
    end

    logic [7:0]  r1_b, r1_g, r1_r, r1_max, r1_min, r1_f;
    logic [9:0]  r1_sum;
    logic [16:0] r1_recip;
    rgb2g_pkg::t_gray_method r1_method;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_b      <= i_blue;
            r1_g      <= i_green;
            r1_r      <= i_red;
            r1_max    <= w_max;
            r1_min    <= w_min;
            r1_sum    <= 10'(i_blue) + 10'(i_green) + 10'(i_red);
            r1_method <= r_method;
            r1_f      <= w_post.factor;
            r1_recip  <= w_post.recip;
        end
    end

    // ---------------- stage 2: weight products, mean product ----------------
    logic [15:0] w_wb, w_wg, w_wr;

    always_comb begin
        if (r1_method == rgb2g_pkg::M_REC709) begin
            w_wb = rgb2g_pkg::W709_B;
            w_wg = rgb2g_pkg::W709_G;
            w_wr = rgb2g_pkg::W709_R;
        end else begin
            w_wb = rgb2g_pkg::W601_B;
            w_wg = rgb2g_pkg::W601_G;
            w_wr = rgb2g_pkg::W601_R;
        end
    end

    logic [23:0] r2_pb, r2_pg, r2_pr;
    logic [19:0] r2_mprod;
    logic [7:0]  r2_b, r2_g, r2_r, r2_max, r2_min, r2_f;
    logic [16:0] r2_recip;
    rgb2g_pkg::t_gray_method r2_method;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_pb     <= 24'(w_wb) * 24'(r1_b);
            r2_pg     <= 24'(w_wg) * 24'(r1_g);
            r2_pr     <= 24'(w_wr) * 24'(r1_r);
            r2_mprod  <= 20'(r1_sum) * 20'(rgb2g_pkg::MEAN_RECIP);
            r2_b      <= r1_b;
            r2_g      <= r1_g;
            r2_r      <= r1_r;
            r2_max    <= r1_max;
            r2_min    <= r1_min;
            r2_f      <= r1_f;
            r2_recip  <= r1_recip;
            r2_method <= r1_method;
        end
    end

    // ---------------- stage 3: weighted sum, mean ----------------
    // weights sum to 65536, so the total stays below 2^24
    logic [23:0] w_wsum;
    assign w_wsum = r2_pb + r2_pg + r2_pr;

    logic [7:0]  r3_wgray, r3_mean, r3_b, r3_g, r3_r, r3_max, r3_min, r3_f;
    logic [16:0] r3_recip;
    rgb2g_pkg::t_gray_method r3_method;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_wgray  <= w_wsum[23:16];
            r3_mean   <= r2_mprod[18:11];
            r3_b      <= r2_b;
            r3_g      <= r2_g;
            r3_r      <= r2_r;
            r3_max    <= r2_max;
            r3_min    <= r2_min;
            r3_f      <= r2_f;
            r3_recip  <= r2_recip;
            r3_method <= r2_method;
        end
    end

    // ---------------- stage 4: posterize quotient product ----------------
    logic [24:0] r4_qprod;
    logic [7:0]  r4_wgray, r4_mean, r4_b, r4_g, r4_r, r4_max, r4_min, r4_f;
    rgb2g_pkg::t_gray_method r4_method;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_qprod  <= 25'(r3_mean) * 25'(r3_recip);
            r4_wgray  <= r3_wgray;
            r4_mean   <= r3_mean;
            r4_b      <= r3_b;
            r4_g      <= r3_g;
            r4_r      <= r3_r;
            r4_max    <= r3_max;
            r4_min    <= r3_min;
            r4_f      <= r3_f;
            r4_method <= r3_method;
        end
    end

    // ---------------- stage 5: quotient times step ----------------
    // quotient is at most the mean, so bits above 23 are zero
    logic [15:0] r5_qf;
    logic [7:0]  r5_wgray, r5_mean, r5_b, r5_g, r5_r, r5_max, r5_min, r5_f;
    rgb2g_pkg::t_gray_method r5_method;

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r5_qf     <= 16'(r4_qprod[23:16]) * 16'(r4_f);
            r5_wgray  <= r4_wgray;
            r5_mean   <= r4_mean;
            r5_b      <= r4_b;
            r5_g      <= r4_g;
            r5_r      <= r4_r;
            r5_max    <= r4_max;
            r5_min    <= r4_min;
            r5_f      <= r4_f;
            r5_method <= r4_method;
        end
    end

    // ---------------- stage 6: method select, output register ----------------
    logic [8:0] w_light, w_post_sum;
    logic [7:0] n_gray, r_gray;

    always_comb begin
        w_light    = 9'(r5_max) + 9'(r5_min);
        // q*f never exceeds the mean, so 9 bits hold q*f + f/2
        w_post_sum = 9'(r5_qf) + 9'(r5_f >> 1);
        case (r5_method)
            rgb2g_pkg::M_MEAN:      n_gray = r5_mean;
            rgb2g_pkg::M_W601:      n_gray = r5_wgray;
            rgb2g_pkg::M_REC709:    n_gray = r5_wgray;
            rgb2g_pkg::M_LIGHTNESS: n_gray = w_light[8:1];
            rgb2g_pkg::M_MAX:       n_gray = r5_max;
            rgb2g_pkg::M_MIN:       n_gray = r5_min;
            rgb2g_pkg::M_BLUE:      n_gray = r5_b;
            rgb2g_pkg::M_GREEN:     n_gray = r5_g;
            rgb2g_pkg::M_RED:       n_gray = r5_r;
            rgb2g_pkg::M_POSTERIZE: n_gray = w_post_sum[8] ? 8'd255 : w_post_sum[7:0];
            default:                n_gray = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en6) begin
            r_gray <= n_gray;
        end
    end

    assign o_gray = r_gray;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for rgb_to_gray_multi_method.
// Depends on rgb2g_pkg (method codes, config indexes, reset values) and the RTL top.
// Pixels and gray values move over valid/ready, both sides idle at random.
module tb;

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    // 16-bit weights, each triple sums to 65536; sum is taken >> 16
    localparam int unsigned K601_B = 7209;
    localparam int unsigned K601_G = 38666;
    localparam int unsigned K601_R = 19661;
    localparam int unsigned K709_B = 4732;
    localparam int unsigned K709_G = 46871;
    localparam int unsigned K709_R = 13933;

    // method codes with no conversion behind them, output must be 0
    localparam logic [3:0] METHOD_UNUSED_LO = 4'd10;
    localparam logic [3:0] METHOD_UNUSED_HI = 4'd15;
    // a register index past the end of the map, writes are dropped
    localparam logic [rgb2g_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 4'd15;

    // pipe is six stages deep; the drain wait leaves margin beyond that
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned RANDOM_PIXELS  = 400;
    localparam int unsigned TIMEOUT_CYCLES = 200000;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    // ------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_cfg_wr_en = 1'b0;
    logic [rgb2g_pkg::CFG_INDEX_W-1:0]    i_cfg_index = '0;
    logic [rgb2g_pkg::CFG_DATA_W-1:0]     i_cfg_data  = '0;
    logic                                 i_valid     = 1'b0;
    logic                                 o_ready;
    logic [7:0]                           i_blue      = '0;
    logic [7:0]                           i_green     = '0;
    logic [7:0]                           i_red       = '0;
    logic                                 o_valid;
    logic                                 i_ready     = 1'b0;
    logic [7:0]                           o_gray;

    rgb_to_gray_multi_method u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_gray      (o_gray)
    );

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------
    t_pixel      pixel_q[$];        // pixels waiting to be driven
    logic [7:0]  gray_q[$];         // predicted gray values, oldest first

    // shadow copy of the config registers
    logic [3:0]  method_now = rgb2g_pkg::METHOD_RESET;
    logic [8:0]  shades_now = rgb2g_pkg::SHADE_RESET;

    logic        pix_taken  = 1'b0; // pixel transaction at the last rising edge
    logic        gray_taken = 1'b0; // gray transaction at the last rising edge

    int unsigned src_gap     = 0;
    int unsigned sink_stall  = 0;
    bit          src_steady  = 1'b0;
    bit          sink_steady = 1'b0;

    int unsigned err_count     = 0;
    int unsigned gray_checked  = 0;
    int unsigned pixels_queued = 0;
    int unsigned phase_count   = 0;
    logic [15:0] methods_seen  = '0;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Gray prediction from the shadow config
    // ------------------------------------------------------------------
    function automatic logic [7:0] expected_gray(input logic [7:0] b, input logic [7:0] g,
                                                 input logic [7:0] r);
        int unsigned bb;
        int unsigned gg;
        int unsigned rr;
        int unsigned avg;
        int unsigned hi;
        int unsigned lo;
        int unsigned lvls;
        int unsigned step;
        int unsigned y;
        bb  = 32'(b);
        gg  = 32'(g);
        rr  = 32'(r);
        avg = (bb + gg + rr) / 3;
        hi  = bb;
        if (gg > hi) hi = gg;
        if (rr > hi) hi = rr;
        lo  = bb;
        if (gg < lo) lo = gg;
        if (rr < lo) lo = rr;
        case (rgb2g_pkg::t_gray_method'(method_now))
            rgb2g_pkg::M_MEAN:      y = avg;
            rgb2g_pkg::M_W601:      y = (K601_B * bb + K601_G * gg + K601_R * rr) >> 16;
            rgb2g_pkg::M_REC709:    y = (K709_B * bb + K709_G * gg + K709_R * rr) >> 16;
            rgb2g_pkg::M_LIGHTNESS: y = (hi + lo) / 2;
            rgb2g_pkg::M_MAX:       y = hi;
            rgb2g_pkg::M_MIN:       y = lo;
            rgb2g_pkg::M_BLUE:      y = bb;
            rgb2g_pkg::M_GREEN:     y = gg;
            rgb2g_pkg::M_RED:       y = rr;
            rgb2g_pkg::M_POSTERIZE: begin
                // shade count clamps to 2..256, step is at least 1
                lvls = 32'(shades_now);
                if (lvls < 2) lvls = 2;
                if (lvls > 256) lvls = 256;
                step = 255 / (lvls - 1);
                y    = (avg / step) * step + step / 2;
            end
            default:                y = 0;
        endcase
        if (y > 255) y = 255;
        return 8'(y);
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    function automatic int unsigned draw_wait(input bit steady);
        return steady ? 0 : $urandom_range(0, 9);
    endfunction

    // channel sample leaning toward the rails
    function automatic logic [7:0] pick_sample();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 8'h00;
        if (sel == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // shade counts around the clamps and the step boundaries
    function automatic logic [8:0] shade_corner(input int unsigned idx);
        case (idx)
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd2;
            3:       return 9'd3;
            4:       return 9'd40;
            5:       return 9'd128;
            6:       return 9'd129;
            7:       return 9'd255;
            8:       return 9'd256;
            9:       return 9'd257;
            default: return 9'd511;
        endcase
    endfunction

    task automatic queue_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        pixel_q.push_back('{blue: b, green: g, red: r});
        pixels_queued++;
    endtask

    // wait for an empty pipe: nothing queued, nothing offered, nothing owed
    task automatic wait_idle();
        @(posedge i_clk);
        while (pixel_q.size() != 0 || i_valid || gray_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rgb2g_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rgb2g_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_method(input logic [3:0] m);
        wait_idle();
        // junk in the unused upper data bits, only [3:0] should land
        write_reg(rgb2g_pkg::CFG_GRAY_METHOD, {5'($urandom_range(0, 31)), m});
        phase_count++;
    endtask

    task automatic set_shades(input logic [8:0] s);
        wait_idle();
        write_reg(rgb2g_pkg::CFG_SHADE_COUNT, s);
        phase_count++;
    endtask

    // random phase setup: method biased toward posterize, shades biased to corners
    task automatic random_config();
        int unsigned pick;
        int unsigned which;
        logic [3:0]  m;
        logic [8:0]  s;
        pick = $urandom_range(0, 19);
        if (pick < 5)       m = rgb2g_pkg::M_POSTERIZE;
        else if (pick < 17) m = 4'($urandom_range(int'(rgb2g_pkg::M_MEAN),
                                                  int'(rgb2g_pkg::M_POSTERIZE)));
        else                m = 4'($urandom_range(METHOD_UNUSED_LO, METHOD_UNUSED_HI));
        if ($urandom_range(0, 1) != 0) s = 9'($urandom_range(0, 511));
        else                           s = shade_corner($urandom_range(0, 10));
        which = $urandom_range(0, 3);
        wait_idle();
        if (which != 1) write_reg(rgb2g_pkg::CFG_GRAY_METHOD, {5'($urandom_range(0, 31)), m});
        if (which != 0) write_reg(rgb2g_pkg::CFG_SHADE_COUNT, s);
        if (which == 3) write_reg(CFG_UNUSED, 9'($urandom_range(0, 511)));
        phase_count++;
    endtask

    // ------------------------------------------------------------------
    // Pixel driver: changes inputs on the falling edge, holds until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_pixels
        t_pixel px;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || pix_taken) begin
            if (src_gap > 0) begin
                src_gap = src_gap - 1;
                i_valid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                px = pixel_q.pop_front();
                i_blue  <= px.blue;
                i_green <= px.green;
                i_red   <= px.red;
                i_valid <= 1'b1;
                // occasionally switch between bursty and back-to-back traffic
                if ($urandom_range(0, 23) == 0) src_steady = !src_steady;
                src_gap = draw_wait(src_steady);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Gray sink: stalls for a random count after each transaction
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_ready
        if (gray_taken) begin
            if ($urandom_range(0, 23) == 0) sink_steady = !sink_steady;
            sink_stall = draw_wait(sink_steady);
        end
        if (sink_stall > 0) begin
            sink_stall = sink_stall - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: tracks config writes, predicts on each pixel transaction,
    // checks each gray transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_ports
        logic [7:0] want;
        if (!i_rst_n) begin
            method_now <= rgb2g_pkg::METHOD_RESET;
            shades_now <= rgb2g_pkg::SHADE_RESET;
            pix_taken  <= 1'b0;
            gray_taken <= 1'b0;
        end else begin
            // writes only happen with the pipe empty, so no pixel sees a half-applied change
            if (i_cfg_wr_en) begin
                if (i_cfg_index == rgb2g_pkg::CFG_GRAY_METHOD) begin
                    method_now <= i_cfg_data[3:0];
                end else if (i_cfg_index == rgb2g_pkg::CFG_SHADE_COUNT) begin
                    shades_now <= i_cfg_data;
                end
            end
            pix_taken <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                gray_q.push_back(expected_gray(i_blue, i_green, i_red));
                methods_seen[method_now] <= 1'b1;
            end
            gray_taken <= o_valid && i_ready;
            if (o_valid && i_ready) begin
                if (gray_q.size() == 0) begin
                    report_mismatch($sformatf("gray %0d with no pixel outstanding", o_gray));
                end else begin
                    want = gray_q.pop_front();
                    gray_checked++;
                    if (o_gray !== want)
                        report_mismatch($sformatf("gray #%0d: got %0d, expected %0d",
                                                  gray_checked, o_gray, want));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned k;
        int unsigned n;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config (mean, 40 shades): rails, single channels, truncation
        queue_pixel(8'd0,   8'd0,   8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0,   8'd0);
        queue_pixel(8'd0,   8'd255, 8'd0);
        queue_pixel(8'd0,   8'd0,   8'd255);
        queue_pixel(8'd1,   8'd1,   8'd2);

        // one pixel per real method after mean; posterize, run last, uses the reset shade count
        for (k = int'(rgb2g_pkg::M_W601); k <= int'(rgb2g_pkg::M_POSTERIZE); k++) begin
            set_method(4'(k));
            queue_pixel(8'(k * 23), 8'(255 - k * 17), 8'(k * 11 + 3));
        end
        // unused codes read as 0
        set_method(METHOD_UNUSED_LO);
        queue_pixel(8'd200, 8'd100, 8'd50);
        set_method(METHOD_UNUSED_HI);
        queue_pixel(8'd255, 8'd255, 8'd255);

        // posterize around the clamps; white with two shades saturates
        set_method(rgb2g_pkg::M_POSTERIZE);
        set_shades(9'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        set_shades(9'd1);
        queue_pixel(8'd128, 8'd127, 8'd126);
        set_shades(9'd2);
        queue_pixel(8'd255, 8'd255, 8'd255);
        set_shades(9'd256);
        queue_pixel(8'd77, 8'd0, 8'd255);
        set_shades(9'd257);
        queue_pixel(8'd3, 8'd200, 8'd91);
        set_shades(9'd511);
        queue_pixel(8'd255, 8'd254, 8'd253);
        // out-of-map write must not touch the shade count
        wait_idle();
        write_reg(CFG_UNUSED, 9'd3);
        queue_pixel(8'd90, 8'd180, 8'd60);

        // random phases, each with its own config
        n = 0;
        while (n < RANDOM_PIXELS) begin
            random_config();
            for (k = $urandom_range(8, 40); k > 0; k--) begin
                queue_pixel(pick_sample(), pick_sample(), pick_sample());
                n++;
            end
        end

        wait_idle();
        $display("Checked %0d gray values from %0d pixels over %0d config changes",
                 gray_checked, pixels_queued, phase_count);
        $display("Method codes exercised (bit per code): %b", methods_seen);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
